// ----- design/tpm_pkg.sv -----
// shared types and constants for the two-position motor move sequencer
`timescale 1ns / 1ps

package tpm_pkg;

  // power scale, Q7.8 percent
  localparam logic [14:0] FULL_POWER = 15'd25600;

  // item kinds
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_MOVE = 1'b1;

  // move targets
  localparam logic [1:0] TARGET_OPEN  = 2'd0;
  localparam logic [1:0] TARGET_CLOSE = 2'd1;

  // motion states
  localparam logic [1:0] MOTION_STOPPED = 2'd0;
  localparam logic [1:0] MOTION_OPENING = 2'd1;
  localparam logic [1:0] MOTION_CLOSING = 2'd2;

  // move results
  localparam logic [1:0] RESULT_NONE        = 2'd0;
  localparam logic [1:0] RESULT_OVERCURRENT = 2'd1;
  localparam logic [1:0] RESULT_TIMEOUT     = 2'd2;

  // event codes
  localparam logic [2:0] EV_NONE        = 3'd0;
  localparam logic [2:0] EV_OVERCURRENT = 3'd1;
  localparam logic [2:0] EV_OPENED      = 3'd2;
  localparam logic [2:0] EV_CLOSED      = 3'd3;
  localparam logic [2:0] EV_TIMEOUT     = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_START_POWER = 2'd0;
  localparam logic [1:0] CFG_RAMP_STEP   = 2'd1;

  // sequencer state apart from the move time counter
  typedef struct packed {
    logic [1:0]  motion;
    logic [1:0]  result;
    logic        opened_latch;
    logic        closed_latch;
    logic [14:0] power_now;
    logic [14:0] power_goal;
    logic [15:0] tick_limit;
    logic        mode_held;
  } tpm_state_t;

  // one result transaction
  typedef struct packed {
    logic [1:0]  motion;
    logic [1:0]  move_result;
    logic [2:0]  event_code;
    logic [14:0] drive_power;
    logic        power_update;
    logic        stop_cmd;
  } tpm_result_t;

endpackage

// ----- design/tpm_step.sv -----
// next-state and result logic for one sequencer transaction
`timescale 1ns / 1ps

module tpm_step #(
  parameter int TIME_BITS = 16
) (
  input  tpm_pkg::tpm_state_t  st,
  input  logic [TIME_BITS-1:0] ticks,
  input  logic [14:0]          start_power,
  input  logic [14:0]          ramp_step,
  input  logic                 func,
  input  logic [1:0]           target_end,
  input  logic [15:0]          wanted_power,
  input  logic [15:0]          time_limit,
  input  logic                 move_mode,
  input  logic                 open_switch,
  input  logic                 close_switch,
  input  logic                 overcurrent_flag,
  output tpm_pkg::tpm_state_t  st_nxt,
  output logic [TIME_BITS-1:0] ticks_nxt,
  output tpm_pkg::tpm_result_t res
);
  import tpm_pkg::*;

  localparam int CW = (TIME_BITS > 16) ? TIME_BITS : 16;

  logic [14:0]          want_clamped;
  logic [TIME_BITS-1:0] ticks_inc;
  logic [CW-1:0]        ticks_cmp;
  logic [CW-1:0]        limit_cmp;
  logic [15:0]          ramp_sum;
  logic [14:0]          ramp_sat;

  // request clamp, counter step and saturating ramp
  assign want_clamped = (wanted_power > {1'b0, FULL_POWER}) ? FULL_POWER : wanted_power[14:0];
  assign ticks_inc    = ticks + 1'b1;
  assign ticks_cmp    = CW'(ticks_inc);
  assign limit_cmp    = CW'(st.tick_limit);
  assign ramp_sum     = {1'b0, st.power_now} + {1'b0, ramp_step};
  assign ramp_sat     = (ramp_sum > {1'b0, FULL_POWER}) ? FULL_POWER : ramp_sum[14:0];

  always_comb begin
    logic [2:0] ev;
    logic       upd;
    logic       stop;
    ev        = EV_NONE;
    upd       = 1'b0;
    stop      = 1'b0;
    st_nxt    = st;
    ticks_nxt = ticks;
    if (func == FUNC_MOVE) begin
      // move request: latch target, load power and clear timing
      if (target_end == TARGET_OPEN) begin
        st_nxt.opened_latch = 1'b0;
        st_nxt.motion       = MOTION_OPENING;
      end else if (target_end == TARGET_CLOSE) begin
        st_nxt.closed_latch = 1'b0;
        st_nxt.motion       = MOTION_CLOSING;
      end
      st_nxt.power_goal = want_clamped;
      st_nxt.power_now  = (start_power > want_clamped) ? want_clamped : start_power;
      st_nxt.result     = RESULT_NONE;
      st_nxt.tick_limit = time_limit;
      st_nxt.mode_held  = move_mode;
      ticks_nxt         = '0;
    end else begin
      // overcurrent stops and reports once
      if (overcurrent_flag) begin
        stop          = 1'b1;
        st_nxt.motion = MOTION_STOPPED;
        if (st.result != RESULT_OVERCURRENT) begin
          st_nxt.result = RESULT_OVERCURRENT;
          ev            = EV_OVERCURRENT;
        end
      end
      // end switch and move-off checks
      if (st_nxt.motion == MOTION_OPENING) begin
        if (!close_switch && st.mode_held) begin
          stop          = 1'b1;
          st_nxt.motion = MOTION_STOPPED;
        end else if (open_switch) begin
          stop          = 1'b1;
          st_nxt.motion = MOTION_STOPPED;
          if (!st.opened_latch) begin
            st_nxt.opened_latch = 1'b1;
            ev                  = EV_OPENED;
          end
        end
      end else if (st_nxt.motion == MOTION_CLOSING) begin
        if (close_switch || (!open_switch && st.mode_held)) begin
          stop          = 1'b1;
          st_nxt.motion = MOTION_STOPPED;
          if (!st.closed_latch) begin
            st_nxt.closed_latch = 1'b1;
            ev                  = EV_CLOSED;
          end
        end
      end
      // move timing and power ramp
      if (st_nxt.motion != MOTION_STOPPED) begin
        ticks_nxt = ticks_inc;
        if (ticks_cmp >= limit_cmp) begin
          stop          = 1'b1;
          st_nxt.motion = MOTION_STOPPED;
          st_nxt.result = RESULT_TIMEOUT;
          ev            = EV_TIMEOUT;
        end else if (st.power_now < st.power_goal) begin
          st_nxt.power_now = ramp_sat;
          upd              = 1'b1;
        end
      end
    end
    res.motion       = st_nxt.motion;
    res.move_result  = st_nxt.result;
    res.event_code   = ev;
    res.drive_power  = st_nxt.power_now;
    res.power_update = upd;
    res.stop_cmd     = stop;
  end

endmodule

// ----- design/two_position_motor_move_sequencer_top.sv -----
// top level of the two-position motor move sequencer
`timescale 1ns / 1ps

// Move sequencer for a motor running between an open and a close end stop.
// Input channel (in_valid / in_stall): one transaction is either a move
// request (in_func 1) or a tick carrying the sensor sample (in_func 0).
// Result channel (out_valid / out_stall): exactly one result per input
// transaction, in order: motion state, move result, event, drive power and
// the set-power and stop command strobes.
// The state and the result register are written at the edge that accepts
// the input. Throughput is one transaction per cycle, set by the single
// result register, while no stalled result waits; the sequencer state is
// updated by one pass of logic in that same cycle.
// When the receiver stalls, the result is held and in_stall rises while a
// result waits; in_stall falls in the cycle the result is taken.
// Configuration (cfg_we, cfg_index, cfg_data) writes start_power (index 0)
// and ramp_step (index 1); other indexes are ignored. Write only when idle.
// Synchronous active-low reset clears the state, both config registers and
// out_valid, not the result data; no clearing pass is needed.
module two_position_motor_move_sequencer_top #(
  parameter int TIME_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [1:0]  in_target_end,
  input  logic [15:0] in_wanted_power,
  input  logic [15:0] in_time_limit,
  input  logic        in_move_mode,
  input  logic        in_open_switch,
  input  logic        in_close_switch,
  input  logic        in_overcurrent_flag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_motion,
  output logic [1:0]  out_move_result,
  output logic [2:0]  out_event_code,
  output logic [14:0] out_drive_power,
  output logic        out_power_update,
  output logic        out_stop_cmd
);
  import tpm_pkg::*;

  logic [14:0]          start_power_r;
  logic [14:0]          ramp_step_r;
  tpm_state_t           st_r;
  tpm_state_t           st_nxt;
  logic [TIME_BITS-1:0] ticks_r;
  logic [TIME_BITS-1:0] ticks_nxt;
  tpm_result_t          res_r;
  tpm_result_t          res_nxt;
  logic                 out_valid_r;
  logic                 in_take;

  // accept while the result register is empty or being drained
  assign in_stall = out_valid_r & out_stall;
  assign in_take  = in_valid & ~in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_power_r <= '0;
      ramp_step_r   <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_START_POWER) start_power_r <= cfg_data;
      if (cfg_index == CFG_RAMP_STEP)   ramp_step_r   <= cfg_data;
    end
  end

  tpm_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .st               (st_r),
    .ticks            (ticks_r),
    .start_power      (start_power_r),
    .ramp_step        (ramp_step_r),
    .func             (in_func),
    .target_end       (in_target_end),
    .wanted_power     (in_wanted_power),
    .time_limit       (in_time_limit),
    .move_mode        (in_move_mode),
    .open_switch      (in_open_switch),
    .close_switch     (in_close_switch),
    .overcurrent_flag (in_overcurrent_flag),
    .st_nxt           (st_nxt),
    .ticks_nxt        (ticks_nxt),
    .res              (res_nxt)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      ticks_r <= '0;
    end else if (in_take) begin
      st_r    <= st_nxt;
      ticks_r <= ticks_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) res_r <= res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_motion       = res_r.motion;
  assign out_move_result  = res_r.move_result;
  assign out_event_code   = res_r.event_code;
  assign out_drive_power  = res_r.drive_power;
  assign out_power_update = res_r.power_update;
  assign out_stop_cmd     = res_r.stop_cmd;

`ifndef SYNTH
  // a stop command always leaves the motor stopped
  a_stop_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.stop_cmd |-> res_r.motion == MOTION_STOPPED)
    else $error("stop command with motor still moving");

  // a power update comes only from a quiet ramping tick
  a_update_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.power_update |->
      res_r.event_code == EV_NONE && !res_r.stop_cmd)
    else $error("power update together with event or stop");

  // drive power never passes full power
  a_power_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> res_r.drive_power <= FULL_POWER)
    else $error("drive power above full scale");

  // timeout event matches the result state
  a_timeout_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.event_code == EV_TIMEOUT |->
      res_r.move_result == RESULT_TIMEOUT)
    else $error("timeout event without timeout result");

  // a move request leaves the power at or below the goal
  a_move_power: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_func == FUNC_MOVE |=> st_r.power_now <= st_r.power_goal)
    else $error("start power above requested power");
`endif

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the two-position motor move sequencer
`timescale 1ns / 1ps

module tb_top;
  import tpm_pkg::*;

  localparam int         CYCLE_LIMIT  = 100000;
  localparam int         HOLD_CYCLES  = 60;
  localparam int         DRAIN_CYCLES = 3;
  // index that maps to no register, written once to show it is ignored
  localparam logic [1:0] CFG_UNUSED   = 2'd3;

  // tracks the sequencer state and holds the responses still to come
  class move_sequencer_scoreboard;
    logic [14:0]  start_power;
    logic [14:0]  ramp_step;
    logic [1:0]   motion;
    logic [1:0]   result;
    logic         opened_latch;
    logic         closed_latch;
    logic [14:0]  power_now;
    logic [14:0]  power_goal;
    logic [15:0]  tick_limit;
    logic [15:0]  ticks_moving;
    logic         mode_held;
    tpm_result_t  expected_results[$];
    int           errors;

    function new();
      start_power  = '0;
      ramp_step    = '0;
      motion       = MOTION_STOPPED;
      result       = RESULT_NONE;
      opened_latch = 1'b0;
      closed_latch = 1'b0;
      power_now    = '0;
      power_goal   = '0;
      tick_limit   = '0;
      ticks_moving = '0;
      mode_held    = 1'b0;
      errors       = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [14:0] value);
      if (index == CFG_START_POWER) start_power = value;
      else if (index == CFG_RAMP_STEP) ramp_step = value;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // next motor response for one accepted transaction
    function void note_item(logic func, logic [1:0] target, logic [15:0] want,
                            logic [15:0] limit, logic mode, logic sw_open,
                            logic sw_close, logic overcurrent);
      tpm_result_t resp;
      int          sum;
      resp = '0;
      if (func == FUNC_MOVE) begin
        if (target == TARGET_OPEN) begin
          opened_latch = 1'b0;
          motion = MOTION_OPENING;
        end else if (target == TARGET_CLOSE) begin
          closed_latch = 1'b0;
          motion = MOTION_CLOSING;
        end
        power_goal   = (want > FULL_POWER) ? FULL_POWER : want[14:0];
        power_now    = (start_power > power_goal) ? power_goal : start_power;
        result       = RESULT_NONE;
        tick_limit   = limit;
        ticks_moving = '0;
        mode_held    = mode;
      end else begin
        // overcurrent stops at once and reports only on the first tick
        if (overcurrent) begin
          resp.stop_cmd = 1'b1;
          motion = MOTION_STOPPED;
          if (result != RESULT_OVERCURRENT) begin
            result = RESULT_OVERCURRENT;
            resp.event_code = EV_OVERCURRENT;
          end
        end
        // end switch, or start switch left in move-off mode
        if (motion == MOTION_OPENING) begin
          if (!sw_close && mode_held) begin
            resp.stop_cmd = 1'b1;
            motion = MOTION_STOPPED;
          end else if (sw_open) begin
            resp.stop_cmd = 1'b1;
            motion = MOTION_STOPPED;
            if (!opened_latch) begin
              opened_latch = 1'b1;
              resp.event_code = EV_OPENED;
            end
          end
        end else if (motion == MOTION_CLOSING) begin
          if (sw_close || (!sw_open && mode_held)) begin
            resp.stop_cmd = 1'b1;
            motion = MOTION_STOPPED;
            if (!closed_latch) begin
              closed_latch = 1'b1;
              resp.event_code = EV_CLOSED;
            end
          end
        end
        // move time, timeout and power ramp
        if (motion != MOTION_STOPPED) begin
          ticks_moving = ticks_moving + 16'd1;
          if (ticks_moving >= tick_limit) begin
            resp.stop_cmd = 1'b1;
            motion = MOTION_STOPPED;
            result = RESULT_TIMEOUT;
            resp.event_code = EV_TIMEOUT;
          end else if (power_now < power_goal) begin
            sum = int'(power_now) + int'(ramp_step);
            power_now = (sum > int'(FULL_POWER)) ? FULL_POWER : 15'(sum);
            resp.power_update = 1'b1;
          end
        end
      end
      resp.motion      = motion;
      resp.move_result = result;
      resp.drive_power = power_now;
      expected_results.push_back(resp);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want,
                 got);
      end
    endfunction

    function void check_result(tpm_result_t got);
      tpm_result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result transaction with nothing expected, actual %0h", $time, got);
        return;
      end
      want = expected_results.pop_front();
      compare_field("motion", want.motion, got.motion);
      compare_field("move_result", want.move_result, got.move_result);
      compare_field("event_code", want.event_code, got.event_code);
      compare_field("drive_power", want.drive_power, got.drive_power);
      compare_field("power_update", want.power_update, got.power_update);
      compare_field("stop_cmd", want.stop_cmd, got.stop_cmd);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [14:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        in_func;
  logic [1:0]  in_target_end;
  logic [15:0] in_wanted_power;
  logic [15:0] in_time_limit;
  logic        in_move_mode;
  logic        in_open_switch;
  logic        in_close_switch;
  logic        in_overcurrent_flag;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_motion;
  logic [1:0]  out_move_result;
  logic [2:0]  out_event_code;
  logic [14:0] out_drive_power;
  logic        out_power_update;
  logic        out_stop_cmd;

  move_sequencer_scoreboard sb;
  int                       items_sent;
  int                       cycle_count;
  int                       hold_request;
  int                       hold_left;
  logic                     quiet;

  two_position_motor_move_sequencer_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_target_end       (in_target_end),
    .in_wanted_power     (in_wanted_power),
    .in_time_limit       (in_time_limit),
    .in_move_mode        (in_move_mode),
    .in_open_switch      (in_open_switch),
    .in_close_switch     (in_close_switch),
    .in_overcurrent_flag (in_overcurrent_flag),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_motion          (out_motion),
    .out_move_result     (out_move_result),
    .out_event_code      (out_event_code),
    .out_drive_power     (out_drive_power),
    .out_power_update    (out_power_update),
    .out_stop_cmd        (out_stop_cmd)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stall: random, quiet, or a long hold-off counted here
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 17);
    end
  end

  // monitor both channels: input transactions first, then results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_item(in_func, in_target_end, in_wanted_power, in_time_limit,
                     in_move_mode, in_open_switch, in_close_switch,
                     in_overcurrent_flag);
      if (out_valid && !out_stall)
        sb.check_result('{motion: out_motion, move_result: out_move_result,
                          event_code: out_event_code, drive_power: out_drive_power,
                          power_update: out_power_update, stop_cmd: out_stop_cmd});
    end
  end

  // offer one transaction and wait for its handshake
  task automatic send_item(input logic func, input logic [1:0] target,
                           input logic [15:0] want, input logic [15:0] limit,
                           input logic mode, input logic sw_open,
                           input logic sw_close, input logic overcurrent);
    while (!quiet && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_func             <= func;
    in_target_end       <= target;
    in_wanted_power     <= want;
    in_time_limit       <= limit;
    in_move_mode        <= mode;
    in_open_switch      <= sw_open;
    in_close_switch     <= sw_close;
    in_overcurrent_flag <= overcurrent;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // move request; the sensor fields are don't-care
  task automatic send_move(input logic [1:0] target, input logic [15:0] want,
                           input logic [15:0] limit, input logic mode);
    send_item(FUNC_MOVE, target, want, limit, mode, 1'($urandom_range(1)),
              1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // tick with sensor sample; the move fields are don't-care
  task automatic send_tick(input logic sw_open, input logic sw_close,
                           input logic overcurrent);
    send_item(FUNC_TICK, 2'($urandom_range(3)), 16'($urandom_range(65535)),
              16'($urandom_range(65535)), 1'($urandom_range(1)), sw_open, sw_close,
              overcurrent);
  endtask

  // stop offering and let every expected result arrive
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [14:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    sb.write_reg(index, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // a move request followed by a run of ticks with plausible sensor values
  task automatic run_move_sequence();
    logic [1:0]  target;
    logic [15:0] want;
    logic [15:0] limit;
    logic        mode;
    logic        start_sw;
    logic        end_sw;
    int          ticks;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 45) target = TARGET_OPEN;
    else if (pick < 90) target = TARGET_CLOSE;
    else target = 2'($urandom_range(2, 3));
    pick = $urandom_range(99);
    if (pick < 50) want = 16'($urandom_range(25600));
    else if (pick < 75) want = 16'($urandom_range(2000));
    else want = 16'($urandom_range(25600, 65535));
    pick = $urandom_range(99);
    if (pick < 70) limit = 16'($urandom_range(24));
    else if (pick < 90) limit = 16'($urandom_range(25, 300));
    else limit = 16'($urandom_range(65535));
    mode = ($urandom_range(99) < 30);
    send_move(target, want, limit, mode);
    ticks = $urandom_range(1, 12);
    repeat (ticks) begin
      // in move-off mode the start switch is mostly still pressed
      start_sw = mode ? ($urandom_range(99) < 75) : ($urandom_range(99) < 30);
      end_sw   = ($urandom_range(99) < 15);
      if (target == TARGET_CLOSE)
        send_tick(start_sw, end_sw, $urandom_range(99) < 4);
      else
        send_tick(end_sw, start_sw, $urandom_range(99) < 4);
    end
  endtask

  // mostly well-formed move sequences, some fully random transactions
  task automatic run_random(input int count);
    int goal;
    goal = items_sent + count;
    while (items_sent < goal) begin
      if ($urandom_range(99) < 15)
        send_item(1'($urandom_range(1)), 2'($urandom_range(3)),
                  16'($urandom_range(65535)), 16'($urandom_range(65535)),
                  1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
      else
        run_move_sequence();
    end
  endtask

  // main sequence
  initial begin
    logic [14:0] start_val;
    logic [14:0] ramp_val;
    sb                  = new();
    items_sent          = 0;
    cycle_count         = 0;
    hold_request        = 0;
    hold_left           = 0;
    quiet               = 1'b0;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_START_POWER;
    cfg_data            = '0;
    in_valid            = 1'b0;
    in_func             = FUNC_TICK;
    in_target_end       = TARGET_OPEN;
    in_wanted_power     = '0;
    in_time_limit       = '0;
    in_move_mode        = 1'b0;
    in_open_switch      = 1'b0;
    in_close_switch     = 1'b0;
    in_overcurrent_flag = 1'b0;
    out_stall           = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle tick, then overcurrent while stopped: event once, stop every time
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    // full-scale request clamped, zero timeout ends the first moving tick
    send_move(TARGET_OPEN, 16'hFFFF, 16'd0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);

    write_reg(CFG_START_POWER, 15'd256);
    write_reg(CFG_RAMP_STEP, 15'd25600);
    write_reg(CFG_UNUSED, 15'h7FFF);
    // ramp saturates at full power, then the close switch ends the move
    send_move(TARGET_CLOSE, 16'd25601, 16'hFFFF, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    // ramp overshoots a low target; overcurrent hides the open switch
    send_move(TARGET_OPEN, 16'd1000, 16'd5, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1);
    // opening in move-off mode: leaving the closed switch stops silently
    send_move(TARGET_OPEN, 16'd0, 16'd100, 1'b1);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    // closing in move-off mode: leaving the open switch raises closed
    send_move(TARGET_CLOSE, 16'd25600, 16'd100, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    // targets without meaning keep the motion state
    send_move(2'd2, 16'd0, 16'd1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_move(2'd3, 16'hFFFF, 16'hFFFF, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);
    send_move(TARGET_OPEN, 16'd25600, 16'd1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);

    // random phases, each under its own register setting
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          start_val = 15'd25600;
          ramp_val  = 15'd25600;
        end
        1: begin
          start_val = 15'd0;
          ramp_val  = 15'd0;
        end
        2: begin
          start_val = 15'($urandom_range(1024));
          ramp_val  = 15'($urandom_range(1, 512));
        end
        3: begin
          start_val = 15'd12800;
          ramp_val  = 15'd1;
        end
        default: begin
          start_val = 15'($urandom_range(25600));
          ramp_val  = 15'($urandom_range(25600));
        end
      endcase
      write_reg(CFG_START_POWER, start_val);
      write_reg(CFG_RAMP_STEP, ramp_val);
      case (phase)
        1: begin
          // receiver holds off while the sender keeps offering
          quiet = 1'b1;
          hold_request = HOLD_CYCLES;
          run_random(80);
          quiet = 1'b0;
          run_random(130);
        end
        2: begin
          // stretch with no idling on either side
          quiet = 1'b1;
          run_random(210);
          quiet = 1'b0;
        end
        3: begin
          run_random(100);
          wait_drained();
          run_random(110);
        end
        default: run_random(210);
      endcase
    end

    wait_drained();
    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
design/tpm_pkg.sv
design/tpm_step.sv
design/two_position_motor_move_sequencer_top.sv
tb/tb_top.sv
